// ===== hdl/coac_pkg.sv =====
// Shared package for the cursor overlay alpha compositor.
// Holds field widths, register indexes, the configuration struct and the blend math.
// No dependencies.
package coac_pkg;

  localparam int CURSOR_DIM_DEFAULT = 64;

  localparam int COL_W      = 14;
  localparam int ROW_W      = 14;
  localparam int PIX_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ROWS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS    = 3'd6;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_COMPOSITE = 1'b1;

  typedef struct packed {
    logic               cursor_enable;
    logic signed [15:0] cursor_left;
    logic signed [15:0] cursor_top;
    logic [6:0]         cursor_cols;
    logic [6:0]         cursor_rows;
    logic [13:0]        frame_cols;
    logic [13:0]        frame_rows;
  } cfg_t;

  // Weighted sum of one channel: p*(255-a) + b*a, which never exceeds 255*255.
  function automatic logic [15:0] mix_sum(logic [7:0] p, logic [7:0] b, logic [7:0] a);
    logic [15:0] m_fb;
    logic [15:0] m_cur;
    m_fb  = 16'(p) * (16'd255 - 16'(a));
    m_cur = 16'(b) * 16'(a);
    return m_fb + m_cur;
  endfunction

  // Divide by 255, rounded down: (s + ((s + 1) << 8)) >> 16.
  function automatic logic [7:0] mix_round(logic [15:0] s);
    logic [23:0] t;
    t = 24'(s) + ((24'(s) + 24'd1) << 8);
    return t[23:16];
  endfunction

endpackage

// ===== hdl/coac_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// The read register only updates when a read is enabled. No dependencies.
module coac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/coac_regs.sv =====
// Configuration register file of the cursor compositor.
// Depends on coac_pkg for register indexes and the cfg_t struct.
module coac_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [coac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [coac_pkg::CFG_DATA_W-1:0]  cfg_data,
  output coac_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        coac_pkg::REG_CURSOR_ENABLE: cfg.cursor_enable <= cfg_data[0];
        coac_pkg::REG_CURSOR_LEFT:   cfg.cursor_left   <= $signed(cfg_data);
        coac_pkg::REG_CURSOR_TOP:    cfg.cursor_top    <= $signed(cfg_data);
        coac_pkg::REG_CURSOR_COLS:   cfg.cursor_cols   <= cfg_data[6:0];
        coac_pkg::REG_CURSOR_ROWS:   cfg.cursor_rows   <= cfg_data[6:0];
        coac_pkg::REG_FRAME_COLS:    cfg.frame_cols    <= cfg_data[13:0];
        coac_pkg::REG_FRAME_ROWS:    cfg.frame_rows    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/coac_hit.sv =====
// Coverage test and image store addressing for one incoming transaction.
// Depends on coac_pkg for the cfg_t struct and field widths.
module coac_hit #(
  parameter int CURSOR_DIM = coac_pkg::CURSOR_DIM_DEFAULT,
  parameter int ADDR_W     = $clog2(CURSOR_DIM * CURSOR_DIM)
) (
  input  coac_pkg::cfg_t                cfg,
  input  logic                          op,
  input  logic [coac_pkg::COL_W-1:0]    pixel_col,
  input  logic [coac_pkg::ROW_W-1:0]    pixel_row,
  output logic                          load_ok,
  output logic                          hit,
  output logic [ADDR_W-1:0]             addr
);

  localparam int IDX_W = $clog2(CURSOR_DIM);
  localparam logic signed [16:0] DIM_S = 17'(CURSOR_DIM);
  localparam logic [coac_pkg::COL_W-1:0] DIM_C = coac_pkg::COL_W'(CURSOR_DIM);

  logic signed [16:0] rc;
  logic signed [16:0] rr;
  logic signed [16:0] span_c;
  logic signed [16:0] span_r;
  logic               in_frame;
  logic               in_cols;
  logic               in_rows;
  logic [IDX_W-1:0]   sel_c;
  logic [IDX_W-1:0]   sel_r;

  // Offsets relative to the cursor origin; 17 bits hold every difference.
  assign rc = $signed({3'b000, pixel_col}) - $signed({cfg.cursor_left[15], cfg.cursor_left});
  assign rr = $signed({3'b000, pixel_row}) - $signed({cfg.cursor_top[15], cfg.cursor_top});

  // An odd cursor size drops its last column or row.
  assign span_c = $signed({10'b0, cfg.cursor_cols[6:1], 1'b0});
  assign span_r = $signed({10'b0, cfg.cursor_rows[6:1], 1'b0});

  assign in_frame = (pixel_col < cfg.frame_cols) && (pixel_row < cfg.frame_rows);
  assign in_cols  = !rc[16] && (rc < span_c) && (rc < DIM_S);
  assign in_rows  = !rr[16] && (rr < span_r) && (rr < DIM_S);

  assign hit     = cfg.cursor_enable && in_frame && in_cols && in_rows;
  assign load_ok = (pixel_col < DIM_C) && (pixel_row < DIM_C);

  assign sel_c = (op == coac_pkg::OP_COMPOSITE) ? rc[IDX_W-1:0] : pixel_col[IDX_W-1:0];
  assign sel_r = (op == coac_pkg::OP_COMPOSITE) ? rr[IDX_W-1:0] : pixel_row[IDX_W-1:0];

  assign addr = ADDR_W'(sel_r) * ADDR_W'(CURSOR_DIM) + ADDR_W'(sel_c);

endmodule

// ===== hdl/cursor_overlay_alpha_compositor.sv =====
// Cursor overlay alpha compositor: blends a stored ARGB cursor over an XRGB pixel stream.
// A pixel transaction passes stages 1 and 2 and the output register. Throughput: one
// transaction per cycle unless stalled; one image store access per cycle sets the rate.
// A load writes the image store at acceptance if its column and row are below CURSOR_DIM,
// and gives no result. Reset clears the configuration registers and pipeline valid bits;
// the image store is not cleared and holds undefined words until loaded.
module cursor_overlay_alpha_compositor #(
  parameter int CURSOR_DIM = coac_pkg::CURSOR_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [coac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [coac_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [coac_pkg::COL_W-1:0]       pixel_col,
  input  logic [coac_pkg::ROW_W-1:0]       pixel_row,
  input  logic [coac_pkg::PIX_W-1:0]       pixel_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [coac_pkg::COL_W-1:0]       out_col,
  output logic [coac_pkg::ROW_W-1:0]       out_row,
  output logic [coac_pkg::PIX_W-1:0]       out_pixel,
  output logic                             covered
);

  localparam int DEPTH  = CURSOR_DIM * CURSOR_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  coac_pkg::cfg_t cfg;

  logic              load_ok;
  logic              hit;
  logic [ADDR_W-1:0] addr;
  logic              acc;
  logic              en1;
  logic              en2;
  logic              en3;
  logic [coac_pkg::PIX_W-1:0] cur_word;

  // Stage 1: item waiting on the store read.
  logic                       v1;
  logic [coac_pkg::COL_W-1:0] col1;
  logic [coac_pkg::ROW_W-1:0] row1;
  logic [coac_pkg::PIX_W-1:0] pix1;
  logic                       hit1;

  // Stage 2: per-channel weighted sums.
  logic                       v2;
  logic [coac_pkg::COL_W-1:0] col2;
  logic [coac_pkg::ROW_W-1:0] row2;
  logic [coac_pkg::PIX_W-1:0] pix2;
  logic                       hit2;
  logic [15:0]                sum_b;
  logic [15:0]                sum_g;
  logic [15:0]                sum_r;

  coac_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  coac_hit #(
    .CURSOR_DIM (CURSOR_DIM),
    .ADDR_W     (ADDR_W)
  ) u_hit (
    .cfg       (cfg),
    .op        (op),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .load_ok   (load_ok),
    .hit       (hit),
    .addr      (addr)
  );

  // Each stage loads when it is empty or its contents move on in the same cycle.
  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign acc      = in_valid && en1;

  // The read register holds its word while stage 1 waits, since a new read
  // is only issued when stage 1 is being refilled.
  coac_ram #(
    .WIDTH (coac_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (acc && (op == coac_pkg::OP_LOAD) && load_ok),
    .waddr (addr),
    .wdata (pixel_value),
    .re    (acc && (op == coac_pkg::OP_COMPOSITE)),
    .raddr (addr),
    .rdata (cur_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= acc && (op == coac_pkg::OP_COMPOSITE);
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      col1 <= pixel_col;
      row1 <= pixel_row;
      pix1 <= pixel_value;
      hit1 <= hit;
    end
    if (en2) begin
      col2  <= col1;
      row2  <= row1;
      pix2  <= pix1;
      hit2  <= hit1;
      sum_b <= coac_pkg::mix_sum(pix1[7:0],   cur_word[7:0],   cur_word[31:24]);
      sum_g <= coac_pkg::mix_sum(pix1[15:8],  cur_word[15:8],  cur_word[31:24]);
      sum_r <= coac_pkg::mix_sum(pix1[23:16], cur_word[23:16], cur_word[31:24]);
    end
    if (en3) begin
      out_col <= col2;
      out_row <= row2;
      covered <= hit2;
      if (hit2) begin
        out_pixel <= {8'h00, coac_pkg::mix_round(sum_r), coac_pkg::mix_round(sum_g),
                      coac_pkg::mix_round(sum_b)};
      end else begin
        out_pixel <= pix2;
      end
    end
  end

endmodule
